// File: sv/dc_pkg.sv
// shared constants, types and command/status structs for the decimal compare block
package dc_pkg;

    // field widths
    localparam int COEF_WIDTH = 64;
    localparam int EXP_WIDTH  = 16;
    // working exponent leaves room for up to eighteen decrements
    localparam int NEXP_WIDTH = EXP_WIDTH + 1;

    // input tdata layout, lowest field first
    localparam int A_COEF_LSB = 0;
    localparam int A_EXP_LSB  = A_COEF_LSB + COEF_WIDTH;
    localparam int B_COEF_LSB = A_EXP_LSB + EXP_WIDTH;
    localparam int B_EXP_LSB  = B_COEF_LSB + COEF_WIDTH;
    localparam int IN_BITS    = B_EXP_LSB + EXP_WIDTH;
    localparam int IN_TDATA_WIDTH  = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout: is_equal in bit 0, is_less in bit 1
    localparam int OUT_BITS        = 2;
    localparam int OUT_TDATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    // normalized magnitudes end in [10^18, 10^19)
    localparam logic [COEF_WIDTH-1:0] NORM_FLOOR = 64'd1000000000000000000;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_CMP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic norm_done;
    } t_dp_stat;

endpackage

// File: sv/dc_ctrl.sv
// controller state machine for the decimal compare block
module dc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output dc_pkg::t_dp_cmd   o_cmd,
    input  dc_pkg::t_dp_stat  i_stat
);

    dc_pkg::t_state r_state, n_state;
    logic           r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            dc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dc_pkg::ST_NORM;
                end
            end
            dc_pkg::ST_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = dc_pkg::ST_CMP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            dc_pkg::ST_CMP: begin
                // wait until the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = dc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/dc_datapath.sv
// operand registers, multiply-by-ten normalizer and compare unit
module dc_datapath (
    input  logic                                i_clk,
    input  logic [dc_pkg::IN_TDATA_WIDTH-1:0]   i_in_data,
    input  dc_pkg::t_dp_cmd                     i_cmd,
    output dc_pkg::t_dp_stat                    o_stat,
    output logic [dc_pkg::OUT_TDATA_WIDTH-1:0]  o_out_data
);

    localparam int CW = dc_pkg::COEF_WIDTH;
    localparam int EW = dc_pkg::EXP_WIDTH;
    localparam int NW = dc_pkg::NEXP_WIDTH;

    logic [CW-1:0]        r_mag_a, r_mag_b;
    logic signed [NW-1:0] r_exp_a, r_exp_b;
    logic                 r_neg_a, r_neg_b;
    logic                 r_zero_a, r_zero_b;
    logic                 r_eq, r_lt;

    logic [CW-1:0] w_coef_a, w_coef_b;
    logic [EW-1:0] w_exp_a, w_exp_b;
    logic [CW-1:0] w_abs_a, w_abs_b;
    logic          w_done_a, w_done_b;
    logic          w_mag_lt, w_mag_gt;
    logic          w_eq, w_lt;

    // unpack the input item
    assign w_coef_a = i_in_data[dc_pkg::A_COEF_LSB +: CW];
    assign w_exp_a  = i_in_data[dc_pkg::A_EXP_LSB  +: EW];
    assign w_coef_b = i_in_data[dc_pkg::B_COEF_LSB +: CW];
    assign w_exp_b  = i_in_data[dc_pkg::B_EXP_LSB  +: EW];

    // magnitudes, the most negative coefficient gives 2^63 unsigned
    assign w_abs_a = w_coef_a[CW-1] ? (CW'(0) - w_coef_a) : w_coef_a;
    assign w_abs_b = w_coef_b[CW-1] ? (CW'(0) - w_coef_b) : w_coef_b;

    // an operand is settled once zero or at the floor
    assign w_done_a = r_zero_a || (r_mag_a >= dc_pkg::NORM_FLOOR);
    assign w_done_b = r_zero_b || (r_mag_b >= dc_pkg::NORM_FLOOR);
    assign o_stat.norm_done = w_done_a && w_done_b;

    // load and normalize both operands side by side
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag_a  <= w_abs_a;
            r_mag_b  <= w_abs_b;
            r_exp_a  <= NW'(signed'(w_exp_a));
            r_exp_b  <= NW'(signed'(w_exp_b));
            r_zero_a <= (w_abs_a == '0);
            r_zero_b <= (w_abs_b == '0);
            r_neg_a  <= w_coef_a[CW-1];
            r_neg_b  <= w_coef_b[CW-1];
        end else if (i_cmd.step) begin
            // times ten as shift by three plus shift by one
            if (!w_done_a) begin
                r_mag_a <= (r_mag_a << 3) + (r_mag_a << 1);
                r_exp_a <= r_exp_a - NW'(1);
            end
            if (!w_done_b) begin
                r_mag_b <= (r_mag_b << 3) + (r_mag_b << 1);
                r_exp_b <= r_exp_b - NW'(1);
            end
        end
    end

    // magnitude order: zero lowest, then exponent, then coefficient
    always_comb begin
        w_mag_lt = 1'b0;
        w_mag_gt = 1'b0;
        if (r_zero_a || r_zero_b) begin
            w_mag_lt = r_zero_a && !r_zero_b;
            w_mag_gt = r_zero_b && !r_zero_a;
        end else if (r_exp_a != r_exp_b) begin
            w_mag_lt = (r_exp_a < r_exp_b);
            w_mag_gt = !(r_exp_a < r_exp_b);
        end else begin
            w_mag_lt = (r_mag_a < r_mag_b);
            w_mag_gt = (r_mag_a > r_mag_b);
        end
    end

    // sign handling, zero counts as non-negative, order flips when both negative
    always_comb begin
        logic sa, sb;
        sa = r_neg_a && !r_zero_a;
        sb = r_neg_b && !r_zero_b;
        if (sa != sb) begin
            w_eq = 1'b0;
            w_lt = sa;
        end else begin
            w_eq = !w_mag_lt && !w_mag_gt;
            w_lt = sa ? w_mag_gt : w_mag_lt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_eq <= w_eq;
            r_lt <= w_lt;
        end
    end

    assign o_out_data = {{(dc_pkg::OUT_TDATA_WIDTH - dc_pkg::OUT_BITS){1'b0}}, r_lt, r_eq};

endmodule

// File: sv/decimal_compare.sv
// top level of the decimal compare block: stream ports, controller and datapath
// an accepted item is loaded, then both operands go through a multiply-by-ten loop that
// runs until both are scaled, its length set by the operand with the smaller nonzero
// magnitude (at most eighteen steps), then compared; the result is captured once the
// output register is free or being drained, and only then does the input take a new item
// reset: synchronous active low, clears the controller state and output valid
module decimal_compare (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // first_coefficient, first_exponent, second_coefficient, second_exponent
    input  logic [dc_pkg::IN_TDATA_WIDTH-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // is_equal, is_less, zero fill
    output logic [dc_pkg::OUT_TDATA_WIDTH-1:0] o_m_axis_tdata
);

    dc_pkg::t_dp_cmd  w_cmd;
    dc_pkg::t_dp_stat w_stat;

    // sequencing
    dc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // normalize and compare
    dc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_in_data  (i_s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // no step is issued once both operands are settled
    a_step_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !w_stat.norm_done)
        else $error("normalize step issued after both operands settled");

    // an accepted item closes the input until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input reopened right after accept");

    // equal and less never both set
    a_eq_lt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("is_equal and is_less both set");

    // a capture never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.capture && o_m_axis_tvalid) |-> i_m_axis_tready)
        else $error("result overwritten before taken");
`endif

endmodule

// File: tb/decimal_compare_tb.sv
// self-checking testbench for decimal_compare: directed table, random items, stream stalls
`timescale 1ns / 1ps

module decimal_compare_tb;

    // one compare request, with an optional hand-written answer for directed rows
    typedef struct packed {
        logic [dc_pkg::COEF_WIDTH-1:0] first_coef;
        logic [dc_pkg::EXP_WIDTH-1:0]  first_exp;
        logic [dc_pkg::COEF_WIDTH-1:0] second_coef;
        logic [dc_pkg::EXP_WIDTH-1:0]  second_exp;
        logic                          fixed;
        logic                          fix_eq;
        logic                          fix_lt;
    } t_compare_op;

    // ordering of the two values as seen on the result stream
    typedef struct packed {
        logic is_equal;
        logic is_less;
    } t_order;

    // operand after sign split and scaling to [10^18, 10^19)
    typedef struct {
        logic                          neg;
        logic                          zero;
        logic [dc_pkg::COEF_WIDTH-1:0] mag;
        int                            nexp;
    } t_scaled;

    localparam int EQ_BIT        = 0;
    localparam int LT_BIT        = 1;
    localparam int N_RANDOM      = 1900;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int MAX_REPORTS   = 10;
    localparam int MODE_INTERVAL = 150;

    localparam logic [dc_pkg::COEF_WIDTH-1:0] SCALE_FLOOR = 64'd1000000000000000000;
    localparam logic [dc_pkg::COEF_WIDTH-1:0] COEF_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [dc_pkg::COEF_WIDTH-1:0] COEF_MAX    = 64'h7fff_ffff_ffff_ffff;
    localparam logic [dc_pkg::EXP_WIDTH-1:0]  EXP_MIN     = 16'h8000;
    localparam logic [dc_pkg::EXP_WIDTH-1:0]  EXP_MAX     = 16'h7fff;

    // directed rows: a, exp a, b, exp b, fixed, is_equal, is_less
    localparam int N_DIRECTED = 23;
    localparam t_compare_op DIRECTED [N_DIRECTED] = '{
        // zero against zero with any exponent
        '{64'd0, 16'h0000, 64'd0, 16'h0000, 1'b1, 1'b1, 1'b0},
        '{64'd0, EXP_MAX, 64'd0, EXP_MIN, 1'b1, 1'b1, 1'b0},
        // zero sits below the smallest positive and above any negative
        '{64'd0, 16'h0000, 64'd1, EXP_MIN, 1'b1, 1'b0, 1'b1},
        '{64'hffff_ffff_ffff_ffff, EXP_MAX, 64'd0, EXP_MIN, 1'b1, 1'b0, 1'b1},
        '{64'd0, 16'h0000, 64'hffff_ffff_ffff_ffff, 16'h0000, 1'b1, 1'b0, 1'b0},
        // most negative coefficient, magnitude 2^63
        '{COEF_MIN, 16'h0000, COEF_MIN, 16'h0000, 1'b1, 1'b1, 1'b0},
        '{COEF_MIN, 16'h0000, COEF_MAX, 16'h0000, 1'b1, 1'b0, 1'b1},
        '{COEF_MAX, 16'h0000, COEF_MAX, 16'h0000, 1'b1, 1'b1, 1'b0},
        '{COEF_MAX, EXP_MAX, COEF_MIN, EXP_MAX, 1'b1, 1'b0, 1'b0},
        // same value written two ways, positive and negative
        '{64'd1, 16'h0000, 64'd10, 16'hffff, 1'b1, 1'b1, 1'b0},
        '{64'hffff_ffff_ffff_ffff, 16'h0000, 64'hffff_ffff_ffff_fff6, 16'hffff,
          1'b1, 1'b1, 1'b0},
        // negative ordering flips
        '{64'hffff_ffff_ffff_fffe, 16'h0000, 64'hffff_ffff_ffff_ffff, 16'h0000,
          1'b1, 1'b0, 1'b1},
        '{64'hffff_ffff_ffff_ffff, 16'h0000, 64'hffff_ffff_ffff_fffe, 16'h0000,
          1'b1, 1'b0, 1'b0},
        // exponent extremes
        '{64'd1, EXP_MIN, 64'd1, EXP_MAX, 1'b1, 1'b0, 1'b1},
        '{64'hffff_ffff_ffff_ffff, EXP_MIN, 64'hffff_ffff_ffff_ffff, EXP_MAX,
          1'b1, 1'b0, 1'b0},
        // full eighteen scaling steps against an already scaled value
        '{SCALE_FLOOR, 16'h0000, 64'd1, 16'd18, 1'b1, 1'b1, 1'b0},
        '{64'd1, 16'h0000, SCALE_FLOOR, 16'hffee, 1'b1, 1'b1, 1'b0},
        '{64'd999999999999999999, 16'h0000, SCALE_FLOOR, 16'h0000, 1'b1, 1'b0, 1'b1},
        '{COEF_MAX, 16'h0000, 64'd1, 16'd19, 1'b1, 1'b0, 1'b1},
        '{COEF_MIN, EXP_MIN, 64'd1, EXP_MIN, 1'b1, 1'b0, 1'b1},
        // scaled exponent drops below the field range
        '{64'd5, EXP_MIN, 64'd50, EXP_MIN, 1'b1, 1'b0, 1'b1},
        // ordinary values left to the predictor
        '{64'd314159, 16'hfffb, 64'd31416, 16'hfffc, 1'b0, 1'b0, 1'b0},
        '{-64'sd271828, 16'd7, -64'sd2718281, 16'd6, 1'b0, 1'b0, 1'b0}
    };

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [dc_pkg::IN_TDATA_WIDTH-1:0]   i_s_axis_tdata = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [dc_pkg::OUT_TDATA_WIDTH-1:0]  o_m_axis_tdata;

    t_compare_op compare_q[$];
    t_order      pending_order_q[$];
    t_compare_op in_flight;
    int          n_total = 0;
    int          n_accepted = 0;
    int          n_received = 0;
    int          n_equal = 0;
    int          n_less = 0;
    int          fail_count = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          tx_mode = 0;
    int          rx_mode = 0;
    int          idle_cycles = 0;

    decimal_compare uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // split the sign and scale the magnitude up by ten until it reaches 10^18
    function automatic t_scaled scale_decimal(logic [dc_pkg::COEF_WIDTH-1:0] coef,
                                              logic [dc_pkg::EXP_WIDTH-1:0] e);
        t_scaled r;
        r.neg  = coef[dc_pkg::COEF_WIDTH-1];
        r.mag  = r.neg ? (64'd0 - coef) : coef;
        r.nexp = int'($signed(e));
        r.zero = (r.mag == 64'd0);
        if (r.zero) begin
            r.neg  = 1'b0;
            r.nexp = 0;
        end else begin
            while (r.mag < SCALE_FLOOR) begin
                r.mag  = r.mag * 64'd10;
                r.nexp = r.nexp - 1;
            end
        end
        return r;
    endfunction

    // order by sign, then zero, exponent and magnitude, flipped for two negatives
    function automatic t_order decimal_order(t_compare_op op);
        t_scaled a;
        t_scaled b;
        int      c;
        t_order  res;
        a = scale_decimal(op.first_coef, op.first_exp);
        b = scale_decimal(op.second_coef, op.second_exp);
        if (a.neg != b.neg) begin
            res.is_equal = 1'b0;
            res.is_less  = a.neg;
        end else begin
            if (a.zero || b.zero)
                c = (a.zero && b.zero) ? 0 : (a.zero ? -1 : 1);
            else if (a.nexp != b.nexp)
                c = (a.nexp < b.nexp) ? -1 : 1;
            else if (a.mag != b.mag)
                c = (a.mag < b.mag) ? -1 : 1;
            else
                c = 0;
            if (a.neg)
                c = -c;
            res.is_equal = (c == 0);
            res.is_less  = (c < 0);
        end
        return res;
    endfunction

    // idle length: mode 0 never idles, higher modes idle more often
    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 80 - 15 * mode)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [dc_pkg::COEF_WIDTH-1:0] pick_edge_coef();
        case ($urandom_range(0, 5))
            0: return COEF_MIN;
            1: return COEF_MAX;
            2: return 64'd1;
            3: return 64'hffff_ffff_ffff_ffff;
            4: return 64'd0;
            default: return SCALE_FLOOR;
        endcase
    endfunction

    function automatic logic [dc_pkg::EXP_WIDTH-1:0] pick_edge_exp();
        case ($urandom_range(0, 4))
            0: return EXP_MIN;
            1: return EXP_MAX;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // request side: one item in flight, random gaps after each accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (in_flight.fixed)
                    pending_order_q.push_back(t_order'{in_flight.fix_eq, in_flight.fix_lt});
                else
                    pending_order_q.push_back(decimal_order(in_flight));
                n_accepted++;
                if (n_accepted % MODE_INTERVAL == 0) begin
                    tx_mode = $urandom_range(0, 3);
                    rx_mode = $urandom_range(0, 3);
                end
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0 || compare_q.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    in_flight = compare_q.pop_front();
                    i_s_axis_tdata <= dc_pkg::IN_TDATA_WIDTH'({in_flight.second_exp,
                        in_flight.second_coef, in_flight.first_exp, in_flight.first_coef});
                    i_s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(tx_mode);
                end
            end
        end
    end

    // result side: check each accepted item against the oldest pending order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_received++;
                if (pending_order_q.size() == 0) begin
                    report_failure($sformatf("unexpected result tdata=%h", o_m_axis_tdata));
                end else begin
                    t_order want;
                    want = pending_order_q.pop_front();
                    if (o_m_axis_tdata[EQ_BIT] !== want.is_equal ||
                        o_m_axis_tdata[LT_BIT] !== want.is_less)
                        report_failure($sformatf(
                            "result %0d: is_equal exp %b got %b, is_less exp %b got %b",
                            n_received, want.is_equal, o_m_axis_tdata[EQ_BIT],
                            want.is_less, o_m_axis_tdata[LT_BIT]));
                    if (want.is_equal)
                        n_equal++;
                    if (want.is_less)
                        n_less++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                stall_left = pick_gap(rx_mode);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // stimulus build, reset, drain and verdict
    initial begin
        t_compare_op                   op;
        logic [dc_pkg::COEF_WIDTH-1:0] c1;
        logic [dc_pkg::COEF_WIDTH-1:0] c2;
        logic [dc_pkg::COEF_WIDTH-1:0] scale;
        logic [dc_pkg::EXP_WIDTH-1:0]  e1;
        logic [dc_pkg::EXP_WIDTH-1:0]  e2;
        int                            kind;
        int                            k;
        int                            signs;

        for (int i = 0; i < N_DIRECTED; i++)
            compare_q.push_back(DIRECTED[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            c1 = {$urandom, $urandom};
            c2 = {$urandom, $urandom};
            e1 = 16'($urandom);
            e2 = 16'($urandom);
            signs = $urandom_range(0, 3);
            case (kind)
                // equal value in two spellings, sometimes nudged by one unit or one exponent step
                2, 3, 4: begin
                    k = $urandom_range(0, 12);
                    scale = 64'd1;
                    for (int j = 0; j < k; j++)
                        scale = scale * 64'd10;
                    c1 = 64'($urandom_range(1, 999999));
                    c2 = c1 * scale;
                    e1 = 16'($urandom_range(0, 60000) - 30000);
                    e2 = e1 - 16'(k);
                    if (kind == 4) begin
                        case ($urandom_range(0, 2))
                            0: c2 = c2 + 64'd1;
                            1: c2 = c2 - 64'd1;
                            default: e2 = e2 + 16'd1;
                        endcase
                    end
                    if (signs[0]) begin
                        c1 = -c1;
                        c2 = -c2;
                    end
                    if (signs[1]) begin
                        {c1, c2} = {c2, c1};
                        {e1, e2} = {e2, e1};
                    end
                end
                // large magnitudes with equal exponents, equal, one bit apart or unrelated
                5: begin
                    c1[dc_pkg::COEF_WIDTH-1] = 1'b0;
                    case ($urandom_range(0, 2))
                        0: c2 = c1;
                        1: c2 = c1 ^ (64'd1 << $urandom_range(0, 62));
                        default: c2[dc_pkg::COEF_WIDTH-1] = 1'b0;
                    endcase
                    e2 = e1;
                    if (signs != 1 && signs != 2) begin
                        if (signs[0]) begin
                            c1 = -c1;
                            c2 = -c2;
                        end
                    end else begin
                        if (signs[0])
                            c1 = -c1;
                        if (signs[1])
                            c2 = -c2;
                    end
                end
                // short coefficients with nearby exponents: long scaling runs
                6: begin
                    c1 = 64'($urandom_range(0, 99999) >> $urandom_range(0, 16));
                    c2 = 64'($urandom_range(0, 99999) >> $urandom_range(0, 16));
                    e2 = e1 + 16'($urandom_range(0, 8)) - 16'd4;
                    if (signs[0])
                        c1 = -c1;
                    if (signs[1])
                        c2 = -c2;
                end
                // zero on one or both sides
                7: begin
                    if (signs != 2)
                        c1 = 64'd0;
                    if (signs != 1)
                        c2 = 64'd0;
                end
                // field extremes
                8: begin
                    c1 = pick_edge_coef();
                    c2 = pick_edge_coef();
                    e1 = pick_edge_exp();
                    e2 = pick_edge_exp();
                end
                // same magnitude, opposite sign
                9: begin
                    c2 = -c1;
                    e2 = e1;
                end
                // raw random bits
                default: ;
            endcase
            op = '{c1, e1, c2, e2, 1'b0, 1'b0, 1'b0};
            compare_q.push_back(op);
        end
        n_total = compare_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || pending_order_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("compared %0d pairs (%0d directed): %0d equal, %0d less, %0d greater",
                 n_received, N_DIRECTED, n_equal, n_less, n_received - n_equal - n_less);
        $display("failures: %0d, results still pending: %0d",
                 fail_count, pending_order_q.size());
        if (fail_count == 0 && pending_order_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
